// ===== hw/rtl/overwriting_ring_offset_lookup_assert.svh =====
// Assertion macros for the overwriting ring offset lookup block.
// Uses the clk_i and rst_ni names of the module that includes it; no other dependencies.
`ifndef OVERWRITING_RING_OFFSET_LOOKUP_ASSERT_SVH
`define OVERWRITING_RING_OFFSET_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define ORL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define ORL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define ORL_ASSERT(lbl, prop, msg)
`define ORL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/orl_pkg.sv =====
// Package for the overwriting ring offset lookup block: sizes, payload types,
// operation codes and the ring index helper. No dependencies.
`timescale 1ns / 1ps

package orl_pkg;

  // Ring geometry and derived widths.
  localparam int RING_DEPTH = 16;
  localparam int HANDLE_W   = 32;
  localparam int LEN_W      = 16;
  localparam int OFS_W      = 20;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = LEN_W + CNT_W;
  localparam int CMP_W      = (SUM_W > OFS_W) ? SUM_W : OFS_W;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [OFS_W-1:0]    offset_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // One ring entry as stored in memory.
  typedef struct packed {
    handle_t handle;
    len_t    len;
  } entry_t;

  // Advance a ring index with wraparound.
  function automatic idx_t next_idx(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/overwriting_ring_offset_lookup.sv =====
// Overwriting ring of (handle, length) entries with a byte offset lookup.
// Depends on orl_pkg and overwriting_ring_offset_lookup_assert.svh.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------------
//   in      | in_valid_i, in_stall_o  | operation, entry_handle, entry_size, byte_offset
//   out     | out_valid_o, out_stall_i| found, found_handle, found_size, byte_in_entry
//
// An add does the memory write at acceptance, then passes through the result stage.
// A find walks the entries from the oldest, reading one stored length per cycle from the
// entry memory, until the offset falls inside an entry or every stored entry is passed.
// Reset clears the indices, the full flag and the output valid flag; the memory is not cleared.
// A stall on the output holds the finished result; input is taken again once it moves to the output registers.
`timescale 1ns / 1ps

`include "overwriting_ring_offset_lookup_assert.svh"

module overwriting_ring_offset_lookup (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  orl_pkg::handle_t entry_handle_i,
  input  orl_pkg::len_t    entry_size_i,
  input  orl_pkg::offset_t byte_offset_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             found_o,
  output orl_pkg::handle_t found_handle_o,
  output orl_pkg::len_t    found_size_o,
  output orl_pkg::len_t    byte_in_entry_o
);
  import orl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

  state_e  state_q, state_d;
  idx_t    write_index_q, write_index_d;
  idx_t    read_index_q, read_index_d;
  logic    ring_full_q, ring_full_d;
  idx_t    idx_q, idx_d;
  cnt_t    remain_q, remain_d;
  sum_t    pos_q, pos_d;
  offset_t offset_q, offset_d;
  logic    res_found_q, res_found_d;
  handle_t res_handle_q, res_handle_d;
  len_t    res_size_q, res_size_d;
  len_t    res_byte_q, res_byte_d;
  logic    out_valid_q, out_valid_d;
  logic    out_found_q, out_found_d;
  handle_t out_handle_q, out_handle_d;
  len_t    out_size_q, out_size_d;
  len_t    out_byte_q, out_byte_d;

  entry_t  mem_q [RING_DEPTH];
  entry_t  rd_data_q;
  idx_t    rd_addr;
  logic    mem_we;

  logic    in_accept;
  logic    out_free;
  cnt_t    fill_count;
  idx_t    write_next;
  sum_t    walk_sum;
  logic    walk_hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_we     = in_accept && (operation_i == OP_ADD);

  // Address of the next read: the oldest entry when a find starts, else the walk successor.
  assign rd_addr = (state_q == ST_IDLE) ? read_index_q : next_idx(idx_q);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[write_index_q] <= '{handle: entry_handle_i, len: entry_size_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Number of stored entries.
  always_comb begin
    if (ring_full_q) begin
      fill_count = cnt_t'(RING_DEPTH);
    end else if (write_index_q >= read_index_q) begin
      fill_count = cnt_t'(write_index_q - read_index_q);
    end else begin
      fill_count = cnt_t'(RING_DEPTH) - cnt_t'(read_index_q) + cnt_t'(write_index_q);
    end
  end

  assign write_next = next_idx(write_index_q);

  // Running end of the current entry and the hit test against the searched offset.
  assign walk_sum = pos_q + sum_t'(rd_data_q.len);
  assign walk_hit = CMP_W'(offset_q) < CMP_W'(walk_sum);

  // Next-state logic for the controller, indices and result registers.
  always_comb begin
    state_d       = state_q;
    write_index_d = write_index_q;
    read_index_d  = read_index_q;
    ring_full_d   = ring_full_q;
    idx_d         = idx_q;
    remain_d      = remain_q;
    pos_d         = pos_q;
    offset_d      = offset_q;
    res_found_d   = res_found_q;
    res_handle_d  = res_handle_q;
    res_size_d    = res_size_q;
    res_byte_d    = res_byte_q;
    out_valid_d   = out_valid_q;
    out_found_d   = out_found_q;
    out_handle_d  = out_handle_q;
    out_size_d    = out_size_q;
    out_byte_d    = out_byte_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_found_d  = 1'b0;
          res_handle_d = '0;
          res_size_d   = '0;
          res_byte_d   = '0;
          if (operation_i == OP_ADD) begin
            // The add that reaches the read index fills the ring; later adds drag it along.
            if (write_next == read_index_q) begin
              ring_full_d = 1'b1;
            end
            if (ring_full_d && (read_index_q == write_index_q)) begin
              read_index_d = next_idx(read_index_q);
            end
            write_index_d = write_next;
            state_d       = ST_RESP;
          end else begin
            idx_d    = read_index_q;
            remain_d = fill_count;
            pos_d    = '0;
            offset_d = byte_offset_i;
            state_d  = (fill_count == '0) ? ST_RESP : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          res_found_d  = 1'b1;
          res_handle_d = rd_data_q.handle;
          res_size_d   = rd_data_q.len;
          res_byte_d   = offset_q[LEN_W-1:0] - pos_q[LEN_W-1:0];
          state_d      = ST_RESP;
        end else begin
          pos_d    = walk_sum;
          idx_d    = next_idx(idx_q);
          remain_d = remain_q - cnt_t'(1);
          if (remain_q == cnt_t'(1)) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_handle_d = res_handle_q;
          out_size_d   = res_size_q;
          out_byte_d   = res_byte_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, indices and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      write_index_q <= '0;
      read_index_q  <= '0;
      ring_full_q   <= 1'b0;
      idx_q         <= '0;
      remain_q      <= '0;
      pos_q         <= '0;
      offset_q      <= '0;
      res_found_q   <= 1'b0;
      res_handle_q  <= '0;
      res_size_q    <= '0;
      res_byte_q    <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_handle_q  <= '0;
      out_size_q    <= '0;
      out_byte_q    <= '0;
    end else begin
      state_q       <= state_d;
      write_index_q <= write_index_d;
      read_index_q  <= read_index_d;
      ring_full_q   <= ring_full_d;
      idx_q         <= idx_d;
      remain_q      <= remain_d;
      pos_q         <= pos_d;
      offset_q      <= offset_d;
      res_found_q   <= res_found_d;
      res_handle_q  <= res_handle_d;
      res_size_q    <= res_size_d;
      res_byte_q    <= res_byte_d;
      out_valid_q   <= out_valid_d;
      out_found_q   <= out_found_d;
      out_handle_q  <= out_handle_d;
      out_size_q    <= out_size_d;
      out_byte_q    <= out_byte_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign found_handle_o  = out_handle_q;
  assign found_size_o    = out_size_q;
  assign byte_in_entry_o = out_byte_q;

  // Checks on the controller and the ring indices.
  `ORL_ASSERT(a_walk_cnt, (state_q == ST_WALK) |-> (remain_q != '0), "walk with no entries")
  `ORL_ASSERT(a_full_idx, ring_full_q |-> (write_index_q == read_index_q), "split indices")
  `ORL_ASSERT(a_hit_len, res_found_q |-> (res_size_q != '0), "hit on an empty entry")
  `ORL_ASSERT_NEXT(a_add_resp, mem_we, state_q == ST_RESP, "add skipped result stage")

endmodule
